/* hdl/vtp_pkg.sv */
// Shared constants, types and helper functions for the vertex transform and projection pipeline.
package vtp_pkg;

    localparam int SCREEN_W = 640;
    localparam int SCREEN_H = 480;

    localparam int DATA_W     = 32;
    localparam int Q_FRAC     = 16;
    localparam int ONE_Q16    = 1 << Q_FRAC;
    localparam int WIDE_W     = 64;
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = $clog2(NUM_REGS);
    localparam int CFG_DATA_W = 2 * DATA_W;

    localparam int DIM_MAX = (SCREEN_W > SCREEN_H) ? SCREEN_W : SCREEN_H;
    localparam int DIM_W   = $clog2(DIM_MAX + 1);
    localparam int NUM_W   = DATA_W + Q_FRAC + DIM_W;
    localparam int DEN_W   = DATA_W + DIM_W;
    localparam int QUO_W   = DATA_W;
    localparam int QIDX_W  = $clog2(QUO_W);
    localparam int REM_W   = DEN_W + QUO_W;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int SCR_W   = DATA_W + DIM_W + 2;

    typedef logic signed [DATA_W-1:0] q16_t;

    localparam q16_t Q16_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam q16_t Q16_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        q16_t x;
        q16_t y;
        q16_t z;
        q16_t w;
    } vec4_t;

    typedef logic [NUM_REGS-1:0][CFG_DATA_W-1:0] coef_bank_t;

    localparam logic [CFG_DATA_W-1:0] ONE_LO = CFG_DATA_W'(ONE_Q16);
    localparam logic [CFG_DATA_W-1:0] ONE_HI = ONE_LO << DATA_W;
    localparam coef_bank_t COEF_RESET = '{ONE_HI, '0, ONE_LO, '0, '0, ONE_HI, '0, ONE_LO};

    typedef struct packed {
        vec4_t view;
        q16_t  ndc_x;
        q16_t  ndc_y;
        logic  zero;
    } proj_t;

    typedef struct packed {
        vec4_t view;
        q16_t  ndc_x;
        q16_t  ndc_y;
        q16_t  screen_x;
        q16_t  screen_y;
        logic  zero;
    } result_t;

    function automatic q16_t sat_q16(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi_lim;
        logic signed [WIDE_W-1:0] lo_lim;
        q16_t r;
        hi_lim = WIDE_W'(Q16_MAX);
        lo_lim = WIDE_W'(Q16_MIN);
        if (v > hi_lim) begin
            r = Q16_MAX;
        end else if (v < lo_lim) begin
            r = Q16_MIN;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

/* hdl/vtp_matrix.sv */
// Row vector by 4x4 matrix product: multiply, pairwise add, final sum with floor and saturation.
module vtp_matrix import vtp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  vec4_t      pos,
    input  coef_bank_t coef,
    output logic       out_valid,
    output vec4_t      view
);

    q16_t pos_a [4];
    q16_t coef_s [4][4];

    logic signed [PROD_W-1:0] prod_reg [4][4];
    logic signed [PROD_W:0]   pair_reg [4][2];
    logic signed [SUM_W-1:0]  col_sum  [4];
    q16_t                     view_next [4];
    q16_t                     view_reg  [4];
    logic                     v1_reg, v2_reg, v3_reg;

    assign pos_a[0] = pos.x;
    assign pos_a[1] = pos.y;
    assign pos_a[2] = pos.z;
    assign pos_a[3] = pos.w;

    for (genvar c = 0; c < 4; c++) begin : g_col
        for (genvar i = 0; i < 4; i++) begin : g_row
            assign coef_s[i][c] = coef[i*2 + c/2][(c%2)*DATA_W +: DATA_W];

            always_ff @(posedge aclk) begin
                if (en) begin
                    prod_reg[c][i] <= PROD_W'(pos_a[i]) * PROD_W'(coef_s[i][c]);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                pair_reg[c][0] <= (PROD_W+1)'(prod_reg[c][0]) + (PROD_W+1)'(prod_reg[c][1]);
                pair_reg[c][1] <= (PROD_W+1)'(prod_reg[c][2]) + (PROD_W+1)'(prod_reg[c][3]);
                view_reg[c]    <= view_next[c];
            end
        end

        always_comb begin
            col_sum[c]   = SUM_W'(pair_reg[c][0]) + SUM_W'(pair_reg[c][1]);
            view_next[c] = sat_q16(WIDE_W'(signed'(col_sum[c][SUM_W-1:Q_FRAC])));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign view.x    = view_reg[0];
    assign view.y    = view_reg[1];
    assign view.z    = view_reg[2];
    assign view.w    = view_reg[3];

endmodule

/* hdl/vtp_project.sv */
// Perspective divide: magnitude setup, range check, one quotient bit per stage, sign and saturation.
module vtp_project import vtp_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  vec4_t view,
    output logic  out_valid,
    output proj_t proj
);

    localparam int LAST = QUO_W + 1;

    typedef struct packed {
        vec4_t             view;
        logic [REM_W-1:0]  rem_x;
        logic [REM_W-1:0]  rem_y;
        logic [DEN_W-1:0]  den;
        logic [QUO_W-1:0]  q_x;
        logic [QUO_W-1:0]  q_y;
        logic              ovf_x;
        logic              ovf_y;
    } div_t;

    function automatic logic [DATA_W-1:0] mag_q16(input q16_t a);
        return a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
    endfunction

    function automatic div_t div_step(input div_t s, input logic [QIDX_W-1:0] k);
        div_t             r;
        logic [REM_W-1:0] dk;
        r  = s;
        dk = REM_W'(s.den) << k;
        if (s.rem_x >= dk) begin
            r.rem_x    = s.rem_x - dk;
            r.q_x[k]   = 1'b1;
        end
        if (s.rem_y >= dk) begin
            r.rem_y    = s.rem_y - dk;
            r.q_y[k]   = 1'b1;
        end
        return r;
    endfunction

    function automatic q16_t ndc_of(input q16_t num, input q16_t vz,
                                    input logic [QUO_W-1:0] q, input logic ovf);
        q16_t r;
        if (vz == '0) begin
            if (num[DATA_W-1]) begin
                r = Q16_MIN;
            end else if (num != '0) begin
                r = Q16_MAX;
            end else begin
                r = '0;
            end
        end else if (num[DATA_W-1] ^ vz[DATA_W-1]) begin
            if (ovf || (q[QUO_W-1] && (|q[QUO_W-2:0]))) begin
                r = Q16_MIN;
            end else begin
                r = signed'(-q);
            end
        end else begin
            if (ovf || q[QUO_W-1]) begin
                r = Q16_MAX;
            end else begin
                r = signed'(q);
            end
        end
        return r;
    endfunction

    div_t  setup;
    div_t  check;
    div_t  stg_reg [LAST+1];
    logic  vld_reg [LAST+1];
    proj_t proj_next;
    proj_t proj_reg;
    logic  out_vld_reg;

    always_comb begin
        setup.view  = view;
        setup.rem_x = REM_W'(NUM_W'(mag_q16(view.x)) * NUM_W'(SCREEN_H)) << Q_FRAC;
        setup.rem_y = REM_W'(NUM_W'(mag_q16(view.y)) * NUM_W'(SCREEN_H)) << Q_FRAC;
        setup.den   = DEN_W'(mag_q16(view.z)) * DEN_W'(SCREEN_W);
        setup.q_x   = '0;
        setup.q_y   = '0;
        setup.ovf_x = 1'b0;
        setup.ovf_y = 1'b0;
    end

    always_comb begin
        check       = stg_reg[0];
        check.ovf_x = stg_reg[0].rem_x >= {stg_reg[0].den, {QUO_W{1'b0}}};
        check.ovf_y = stg_reg[0].rem_y >= {stg_reg[0].den, {QUO_W{1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stg_reg[0] <= setup;
            stg_reg[1] <= check;
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        always_ff @(posedge aclk) begin
            if (en) begin
                stg_reg[j+2] <= div_step(stg_reg[j+1], QIDX_W'(QUO_W - 1 - j));
            end
        end
    end

    always_comb begin
        proj_next.view  = stg_reg[LAST].view;
        proj_next.ndc_x = ndc_of(stg_reg[LAST].view.x, stg_reg[LAST].view.z,
                                 stg_reg[LAST].q_x, stg_reg[LAST].ovf_x);
        proj_next.ndc_y = ndc_of(stg_reg[LAST].view.y, stg_reg[LAST].view.z,
                                 stg_reg[LAST].q_y, stg_reg[LAST].ovf_y);
        proj_next.zero  = (stg_reg[LAST].view.z == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            proj_reg <= proj_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= LAST; k++) begin
                vld_reg[k] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int k = 0; k < LAST; k++) begin
                vld_reg[k+1] <= vld_reg[k];
            end
            out_vld_reg <= vld_reg[LAST];
        end
    end

    assign out_valid = out_vld_reg;
    assign proj      = proj_reg;

endmodule

/* hdl/vtp_screen.sv */
// Screen mapping: scale by screen size, add offset, halve toward zero and saturate.
module vtp_screen import vtp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  logic    in_valid,
    input  proj_t   proj,
    output logic    out_valid,
    output result_t res
);

    localparam logic signed [SCR_W-1:0] X_OFS = SCR_W'(SCREEN_W * ONE_Q16);
    localparam logic signed [SCR_W-1:0] Y_OFS = SCR_W'(SCREEN_H * ONE_Q16);

    function automatic q16_t halve_sat(input logic signed [SCR_W-1:0] v);
        logic signed [SCR_W-1:0] adj;
        logic signed [SCR_W-1:0] half;
        adj  = v + {{(SCR_W-1){1'b0}}, v[SCR_W-1]};
        half = adj >>> 1;
        return sat_q16(WIDE_W'(half));
    endfunction

    logic signed [SCR_W-1:0] mul_x_reg;
    logic signed [SCR_W-1:0] mul_y_reg;
    proj_t                   proj_reg;
    logic                    mul_vld_reg;
    result_t                 res_next;
    result_t                 res_reg;
    logic                    res_vld_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mul_x_reg <= SCR_W'(proj.ndc_x) * SCR_W'(SCREEN_W);
            mul_y_reg <= SCR_W'(proj.ndc_y) * SCR_W'(SCREEN_H);
            proj_reg  <= proj;
            res_reg   <= res_next;
        end
    end

    always_comb begin
        res_next.view     = proj_reg.view;
        res_next.ndc_x    = proj_reg.ndc_x;
        res_next.ndc_y    = proj_reg.ndc_y;
        res_next.zero     = proj_reg.zero;
        res_next.screen_x = halve_sat(mul_x_reg + X_OFS);
        res_next.screen_y = halve_sat(Y_OFS - mul_y_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end else if (en) begin
            mul_vld_reg <= in_valid;
            res_vld_reg <= mul_vld_reg;
        end
    end

    assign out_valid = res_vld_reg;
    assign res       = res_reg;

endmodule

/* hdl/vertex_transform_project.sv */
// Top level: coefficient registers, pipeline flow control and the three processing sections.
//
// Takes one vertex beat per clock while the output is not stalled and returns one result beat
// per vertex, in order, after the matrix product, the perspective divide (setup, range check,
// 32 restoring stages that each settle one quotient bit of both ndc_x and ndc_y against the
// shared view_z divisor, sign fixup and saturation) and the screen mapping. The whole pipeline
// holds while a result beat waits on m_ready, so s_ready follows that single stall. The user
// must load coefficients through the cfg write port only while the pipeline is empty; the
// block itself does not enforce this. Coefficients reset to the identity matrix.
module vertex_transform_project import vtp_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [31:0]    s_pos_x,
    input  logic signed [31:0]    s_pos_y,
    input  logic signed [31:0]    s_pos_z,
    input  logic signed [31:0]    s_pos_w,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_view_x,
    output logic signed [31:0]    m_view_y,
    output logic signed [31:0]    m_view_z,
    output logic signed [31:0]    m_view_w,
    output logic signed [31:0]    m_ndc_x,
    output logic signed [31:0]    m_ndc_y,
    output logic signed [31:0]    m_screen_x,
    output logic signed [31:0]    m_screen_y,
    output logic                  m_depth_zero
);

    coef_bank_t coef_reg;
    logic       en;
    vec4_t      pos;
    logic       mat_valid;
    vec4_t      view;
    logic       proj_valid;
    proj_t      proj;
    logic       res_valid;
    result_t    res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= COEF_RESET;
        end else if (cfg_wr_en) begin
            coef_reg[cfg_addr] <= cfg_wdata;
        end
    end

    // advance whenever the output beat is empty or being taken
    assign en      = !res_valid || m_ready;
    assign s_ready = en;

    assign pos.x = s_pos_x;
    assign pos.y = s_pos_y;
    assign pos.z = s_pos_z;
    assign pos.w = s_pos_w;

    vtp_matrix u_matrix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .pos       (pos),
        .coef      (coef_reg),
        .out_valid (mat_valid),
        .view      (view)
    );

    vtp_project u_project (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (mat_valid),
        .view      (view),
        .out_valid (proj_valid),
        .proj      (proj)
    );

    vtp_screen u_screen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (proj_valid),
        .proj      (proj),
        .out_valid (res_valid),
        .res       (res)
    );

    assign m_valid      = res_valid;
    assign m_view_x     = res.view.x;
    assign m_view_y     = res.view.y;
    assign m_view_z     = res.view.z;
    assign m_view_w     = res.view.w;
    assign m_ndc_x      = res.ndc_x;
    assign m_ndc_y      = res.ndc_y;
    assign m_screen_x   = res.screen_x;
    assign m_screen_y   = res.screen_y;
    assign m_depth_zero = res.zero;

endmodule

/* hdl/vtp_checker.sv */
// Port-level checker for the vertex transform block and its bind to the top level.
module vtp_checker import vtp_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic signed [31:0]    m_view_x,
    input logic signed [31:0]    m_view_z,
    input logic signed [31:0]    m_ndc_x,
    input logic signed [31:0]    m_screen_x,
    input logic                  m_depth_zero
);

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ndc_x) && $stable(m_screen_x))
        else $error("result beat changed while stalled");

    a_zero_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_depth_zero == (m_view_z == '0)))
        else $error("depth_zero does not match view_z");

    a_zero_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_depth_zero && !m_view_x[31] && (m_view_x != '0) |-> m_ndc_x == Q16_MAX)
        else $error("zero depth with positive x did not saturate high");

    a_zero_null: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_depth_zero && (m_view_x == '0) |-> m_ndc_x == '0)
        else $error("zero depth with zero x gave nonzero ndc_x");

    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind vertex_transform_project vtp_checker u_vtp_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_view_x     (m_view_x),
    .m_view_z     (m_view_z),
    .m_ndc_x      (m_ndc_x),
    .m_screen_x   (m_screen_x),
    .m_depth_zero (m_depth_zero)
);
